/* rtl/core/tts_pkg.sv */
package tts_pkg;

   // Field widths of the stream and configuration ports.
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;

   localparam int POS_W    = 21;
   localparam int MODE_W   = 3;
   localparam int ADDR_IN_W = 20;

   // Item kinds.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_MODE  = 2'd1;
   localparam logic [1:0] KIND_LOAD  = 2'd2;
   localparam logic [1:0] KIND_RESET = 2'd3;

   // Transport modes.
   localparam logic [MODE_W-1:0] MODE_STOP = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PLAY = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REC  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FWD  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REW  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_INTERVAL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_STEP      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPE_LENGTH    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOAD_THRESHOLD = 2'd3;

   typedef struct packed {
      logic clear_wr;
      logic latch_item;
      logic prescale;
      logic apply;
      logic mem_rd;
      logic step;
      logic emit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic kind_tick;
      logic deck_valid;
      logic item_deck;
      logic expire_now;
      logic stepped;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/tts_ctrl.sv */
module tts_ctrl #(
   parameter int NUM_DECKS = 2,
   parameter int DECK_IW   = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  tts_pkg::status_type  st,
   output tts_pkg::cmd_type     cmd,
   output logic [DECK_IW-1:0]   deck_sel
);
   import tts_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_STEP   = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   localparam logic [DECK_IW-1:0] LAST_DECK = DECK_IW'(NUM_DECKS - 1);

   logic [2:0]         state_ff, state_in;
   logic [DECK_IW-1:0] deck_ff, deck_in;
   logic               final_emit;

   assign req_tready = (state_ff == S_IDLE);
   assign deck_sel   = deck_ff;
   assign final_emit = !st.kind_tick || (deck_ff == LAST_DECK);

   always_comb begin
      state_in = state_ff;
      deck_in  = deck_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (st.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_item = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.kind_tick) begin
               cmd.prescale = 1'b1;
               deck_in      = '0;
               state_in     = st.expire_now ? S_READ : S_EMIT;
            end else if (!st.deck_valid) begin
               state_in = S_IDLE;
            end else begin
               cmd.apply = 1'b1;
               deck_in   = DECK_IW'(st.item_deck);
               state_in  = S_EMIT;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = final_emit;
               if (final_emit) begin
                  state_in = S_IDLE;
               end else begin
                  deck_in  = deck_ff + 1'b1;
                  state_in = st.stepped ? S_READ : S_EMIT;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         deck_ff  <= '0;
      end else begin
         state_ff <= state_in;
         deck_ff  <= deck_in;
      end
   end

endmodule

/* rtl/core/tts_datapath.sv */
module tts_datapath #(
   parameter int NUM_DECKS  = 2,
   parameter int TAPE_DEPTH = 1048576,
   parameter int DECK_IW    = 1,
   parameter int ADDR_W     = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [tts_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [tts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  tts_pkg::cmd_type                    cmd,
   input  logic [DECK_IW-1:0]                  deck_sel,
   output tts_pkg::status_type                 st
);
   import tts_pkg::*;

   // Configuration registers.
   logic [15:0]      poll_ff;
   logic [12:0]      fstep_ff;
   logic [POS_W-1:0] tlen_ff;
   logic [7:0]       thresh_ff;

   // Latched input item.
   logic [1:0]           kind_ff;
   logic                 ideck_ff;
   logic [MODE_W-1:0]    imode_ff;
   logic [ADDR_IN_W-1:0] iaddr_ff;
   logic [7:0]           ibyte_ff;
   logic [1:0]           imotor_ff;
   logic [1:0]           irec_ff;

   // Deck state.
   logic [POS_W-1:0]  pos_ff   [NUM_DECKS];
   logic [POS_W-1:0]  pos_in   [NUM_DECKS];
   logic [MODE_W-1:0] dmode_ff [NUM_DECKS];
   logic [MODE_W-1:0] dmode_in [NUM_DECKS];
   logic              rbit_ff  [NUM_DECKS];
   logic              rbit_in  [NUM_DECKS];
   logic              rd_bit_ff[NUM_DECKS];

   logic [15:0] presc_ff, presc_in, presc_dec;
   logic        stepped_ff, stepped_in;

   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_deck_ff, out_play_ff, out_stepped_ff, out_last_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic [MODE_W-1:0] out_mode_ff;

   // Step of the selected deck.
   logic [POS_W-1:0]  cur_pos, tape_len;
   logic [MODE_W-1:0] cur_mode, step_mode;
   logic [POS_W:0]    step_pos;
   logic              motor_bit, rec_bit, in_store, step_rbit, step_wr;
   logic [DECK_IW-1:0] item_idx;

   // Shared memory write port.
   logic [ADDR_W-1:0] mem_waddr;
   logic              mem_wdata;
   logic              load_ok, load_bit;

   assign item_idx  = DECK_IW'(ideck_ff);
   assign cur_pos   = pos_ff[deck_sel];
   assign cur_mode  = dmode_ff[deck_sel];
   assign motor_bit = (32'(deck_sel) < 2) ? imotor_ff[deck_sel[0]] : 1'b0;
   assign rec_bit   = (32'(deck_sel) < 2) ? irec_ff[deck_sel[0]] : 1'b0;
   assign in_store  = (32'(cur_pos) < TAPE_DEPTH);
   assign tape_len  = (32'(tlen_ff) > TAPE_DEPTH) ? POS_W'(TAPE_DEPTH) : tlen_ff;
   assign load_ok   = (32'(iaddr_ff) < TAPE_DEPTH);
   assign load_bit  = (ibyte_ff < thresh_ff);

   always_comb begin
      step_pos  = {1'b0, cur_pos};
      step_mode = cur_mode;
      step_rbit = rbit_ff[deck_sel];
      step_wr   = 1'b0;
      case (cur_mode)
         MODE_REW: begin
            if ({1'b0, cur_pos} > (POS_W + 1)'(fstep_ff)) begin
               step_pos = {1'b0, cur_pos} - (POS_W + 1)'(fstep_ff);
            end else begin
               step_pos  = '0;
               step_mode = MODE_STOP;
            end
         end
         MODE_FWD: begin
            step_pos = {1'b0, cur_pos} + (POS_W + 1)'(fstep_ff);
         end
         MODE_PLAY: begin
            if (motor_bit) begin
               step_rbit = in_store ? rd_bit_ff[deck_sel] : 1'b0;
               step_pos  = {1'b0, cur_pos} + 1'b1;
            end
         end
         MODE_REC: begin
            if (motor_bit) begin
               step_wr  = in_store;
               step_pos = {1'b0, cur_pos} + 1'b1;
            end
         end
         default: begin
         end
      endcase
      // The end of tape clamps the position and stops the deck.
      if (step_pos >= {1'b0, tape_len}) begin
         step_pos  = {1'b0, tape_len};
         step_mode = MODE_STOP;
      end
   end

   always_comb begin
      for (int d = 0; d < NUM_DECKS; d++) begin
         pos_in[d]   = pos_ff[d];
         dmode_in[d] = dmode_ff[d];
         rbit_in[d]  = rbit_ff[d];
      end
      if (cmd.step) begin
         pos_in[deck_sel]   = step_pos[POS_W-1:0];
         dmode_in[deck_sel] = step_mode;
         rbit_in[deck_sel]  = step_rbit;
      end
      if (cmd.apply) begin
         case (kind_ff)
            KIND_MODE: begin
               dmode_in[item_idx] = (imode_ff <= MODE_REW) ? imode_ff : MODE_STOP;
            end
            KIND_RESET: begin
               pos_in[item_idx]   = '0;
               dmode_in[item_idx] = MODE_STOP;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DECKS; d++) begin
            pos_ff[d]   <= '0;
            dmode_ff[d] <= MODE_STOP;
            rbit_ff[d]  <= 1'b0;
         end
      end else begin
         for (int d = 0; d < NUM_DECKS; d++) begin
            pos_ff[d]   <= pos_in[d];
            dmode_ff[d] <= dmode_in[d];
            rbit_ff[d]  <= rbit_in[d];
         end
      end
   end

   // Prescaler: a zero reload wraps the 16-bit count.
   assign presc_dec  = presc_ff - 1'b1;
   assign presc_in   = cmd.prescale ? ((presc_dec == '0) ? poll_ff : presc_dec) : presc_ff;
   assign stepped_in = cmd.prescale ? (presc_dec == '0) : stepped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff   <= 16'd1;
         stepped_ff <= 1'b0;
      end else begin
         presc_ff   <= presc_in;
         stepped_ff <= stepped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_ff   <= 16'd1;
         fstep_ff  <= 13'd3;
         tlen_ff   <= 21'd1048576;
         thresh_ff <= 8'd128;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLL_INTERVAL:  poll_ff   <= csr_wdata[15:0];
            CSR_FAST_STEP:      fstep_ff  <= csr_wdata[12:0];
            CSR_TAPE_LENGTH:    tlen_ff   <= csr_wdata[POS_W-1:0];
            CSR_LOAD_THRESHOLD: thresh_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         kind_ff   <= req_tuser[1:0];
         ideck_ff  <= req_tdata[0];
         imode_ff  <= req_tdata[3:1];
         iaddr_ff  <= req_tdata[23:4];
         ibyte_ff  <= req_tdata[31:24];
         imotor_ff <= req_tdata[33:32];
         irec_ff   <= req_tdata[35:34];
      end
   end

   // Clearing pass sweeps all deck stores together.
   assign clr_in = cmd.clear_wr ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_comb begin
      if (cmd.clear_wr) begin
         mem_waddr = clr_ff;
         mem_wdata = 1'b0;
      end else if (cmd.step) begin
         mem_waddr = ADDR_W'(cur_pos);
         mem_wdata = rec_bit;
      end else begin
         mem_waddr = ADDR_W'(iaddr_ff);
         mem_wdata = load_bit;
      end
   end

   for (genvar g = 0; g < NUM_DECKS; g++) begin : g_store
      logic store_mem [TAPE_DEPTH];
      logic store_we;

      assign store_we = cmd.clear_wr
                     || (cmd.step && (32'(deck_sel) == g) && step_wr)
                     || (cmd.apply && (kind_ff == KIND_LOAD) && (32'(ideck_ff) == g)
                         && load_ok);

      always_ff @(posedge clock) begin
         if (store_we) begin
            store_mem[mem_waddr] <= mem_wdata;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.mem_rd) begin
            rd_bit_ff[g] <= store_mem[ADDR_W'(pos_ff[g])];
         end
      end
   end

   // Output register.
   assign out_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_deck_ff    <= deck_sel[0];
         out_play_ff    <= rbit_ff[deck_sel];
         out_pos_ff     <= cur_pos;
         out_mode_ff    <= cur_mode;
         out_stepped_ff <= (kind_ff == KIND_TICK) && stepped_ff;
         out_last_ff    <= cmd.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'd0, out_stepped_ff, out_mode_ff, out_pos_ff, out_play_ff, out_deck_ff};

   assign st.clear_last = (clr_ff == ADDR_W'(TAPE_DEPTH - 1));
   assign st.kind_tick  = (kind_ff == KIND_TICK);
   assign st.deck_valid = (32'(ideck_ff) < NUM_DECKS);
   assign st.item_deck  = ideck_ff;
   assign st.expire_now = (presc_dec == '0);
   assign st.stepped    = stepped_ff;
   assign st.out_free   = !out_valid_ff || rsp_tready;

endmodule

/* rtl/core/tape_transport_sampler_top.sv */
// Channel   Ports                                   Carries
// -------   -------------------------------------   ------------------------------------
// request   req_tvalid/tready/tdata/tuser           one item: kind in tuser, rest in tdata
// response  rsp_tvalid/tready/tdata/tlast           one deck report a beat, tlast on final
// control   csr_we/csr_index/csr_wdata              register write, no read-back
//
// A clock tick reports every deck in turn; when the prescaler expires, each deck step
// is a store read, an update and a report, one deck at a time. Mode, load and deck
// reset items give one report; an item for a missing deck is dropped with no report.
// After reset a clearing pass zeroes the sample stores; no item is taken until it
// ends. A stalled response beat holds its slot and the block waits in the report
// step; the next item is taken while the final beat is still pending.
module tape_transport_sampler_top #(
   parameter int NUM_DECKS  = 2,
   parameter int TAPE_DEPTH = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // deck, mode, sample_addr, sample_byte, motor_on, record_bits
   input  logic [tts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // kind
   input  logic [tts_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // deck_id, play_bit, position, transport_mode, stepped
   output logic [tts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [tts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tts_pkg::*;

   localparam int DECK_IW = (NUM_DECKS > 1) ? $clog2(NUM_DECKS) : 1;
   localparam int ADDR_W  = $clog2(TAPE_DEPTH);

   cmd_type            cmd;
   status_type         st;
   logic [DECK_IW-1:0] deck_sel;

   tts_ctrl #(
      .NUM_DECKS (NUM_DECKS),
      .DECK_IW   (DECK_IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd),
      .deck_sel   (deck_sel)
   );

   tts_datapath #(
      .NUM_DECKS  (NUM_DECKS),
      .TAPE_DEPTH (TAPE_DEPTH),
      .DECK_IW    (DECK_IW),
      .ADDR_W     (ADDR_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .deck_sel   (deck_sel),
      .st         (st)
   );

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in work");

   // A report is never loaded over a beat that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("response beat overwritten");

   // A deck update always uses store data read in the cycle before.
   a_read_first: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> $past(cmd.mem_rd))
      else $error("deck step without a store read");

endmodule
